>>> src/bdl_pkg.sv
// shared types, constants and codes for the bounded deque list
package bdl_pkg;

  // storage geometry
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // fixed port field widths
  localparam int REQ_W   = 4;
  localparam int POS_W   = 5;
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 5;
  localparam int ST_W    = 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [FIELD_W-1:0]   field_t;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 4'd0,
    REQ_PUSH_FRONT = 4'd1,
    REQ_POP_BACK   = 4'd2,
    REQ_POP_FRONT  = 4'd3,
    REQ_READ       = 4'd4,
    REQ_WRITE      = 4'd5,
    REQ_INSERT     = 4'd6,
    REQ_ERASE      = 4'd7,
    REQ_CLEAR      = 4'd8
  } req_e;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } st_e;

  // storage update kinds
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_INSERT,
    OP_ERASE
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TAIL
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic tail;
  } cmd_t;

endpackage

>>> src/bdl_ctrl.sv
// request sequencer: capture, execute, tail read
module bdl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output bdl_pkg::cmd_t cmd
);

  bdl_pkg::state_t state_r;
  bdl_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdl_pkg::S_IDLE: begin
        if (start) state_nxt = bdl_pkg::S_EXEC;
      end
      bdl_pkg::S_EXEC: begin
        state_nxt = bdl_pkg::S_TAIL;
      end
      bdl_pkg::S_TAIL: begin
        state_nxt = bdl_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bdl_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy     = 1'b1;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    cmd.tail = 1'b0;
    unique case (state_r)
      bdl_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      bdl_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      bdl_pkg::S_TAIL: begin
        cmd.tail = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

>>> src/bdl_dpath.sv
// element array, count and result registers
module bdl_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bdl_pkg::cmd_t                 cmd,
  input  logic [bdl_pkg::REQ_W-1:0]     in_req_type,
  input  logic [bdl_pkg::POS_W-1:0]     in_position,
  input  logic signed [bdl_pkg::FIELD_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed [bdl_pkg::FIELD_W-1:0] out_read_value,
  output logic [bdl_pkg::COUNT_W-1:0]   out_count,
  output logic signed [bdl_pkg::FIELD_W-1:0] out_front_value,
  output logic signed [bdl_pkg::FIELD_W-1:0] out_back_value,
  output logic [bdl_pkg::ST_W-1:0]      out_status
);

  // captured request beat
  logic [bdl_pkg::REQ_W-1:0] req_r;
  logic [bdl_pkg::POS_W-1:0] pos_r;
  bdl_pkg::field_t           val_r;

  // element storage and count
  bdl_pkg::word_t            entries_r [bdl_pkg::DEPTH];
  bdl_pkg::word_t            ent_nxt   [bdl_pkg::DEPTH];
  logic [bdl_pkg::CNT_W-1:0] cnt_r;
  logic [bdl_pkg::CNT_W-1:0] cnt_nxt;

  // execute decode
  bdl_pkg::op_e              op;
  logic [bdl_pkg::IDX_W-1:0] op_idx;
  bdl_pkg::st_e              st_nxt;
  logic                      rd_ok;
  logic                      full;
  logic                      empty;
  logic                      pos_ge;
  logic                      pos_gt;
  bdl_pkg::word_t            val_w;

  // shared read port
  logic [bdl_pkg::IDX_W-1:0] rd_addr;
  bdl_pkg::word_t            rd_word;

  // result registers
  bdl_pkg::field_t           rd_r;
  bdl_pkg::st_e              status_r;
  logic                      valid_r;
  bdl_pkg::field_t           read_out_r;
  logic [bdl_pkg::COUNT_W-1:0] count_out_r;
  bdl_pkg::field_t           front_out_r;
  bdl_pkg::field_t           back_out_r;
  logic [bdl_pkg::ST_W-1:0]  status_out_r;

  // capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      pos_r <= in_position;
      val_r <= in_value;
    end
  end

  assign full   = (cnt_r == bdl_pkg::CNT_W'(bdl_pkg::DEPTH));
  assign empty  = (cnt_r == '0);
  assign pos_ge = (32'(pos_r) >= 32'(cnt_r));
  assign pos_gt = (32'(pos_r) > 32'(cnt_r));
  assign val_w  = bdl_pkg::word_t'(bdl_pkg::WORD_BITS'(val_r));

  // request decode
  always_comb begin
    op      = bdl_pkg::OP_NONE;
    op_idx  = '0;
    st_nxt  = bdl_pkg::ST_OK;
    cnt_nxt = cnt_r;
    rd_ok   = 1'b0;
    unique case (req_r)
      bdl_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          st_nxt = bdl_pkg::ST_FULL;
        end else begin
          op      = bdl_pkg::OP_WRITE;
          op_idx  = bdl_pkg::IDX_W'(cnt_r);
          cnt_nxt = cnt_r + bdl_pkg::CNT_W'(1);
        end
      end
      bdl_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          st_nxt = bdl_pkg::ST_FULL;
        end else begin
          op      = bdl_pkg::OP_INSERT;
          cnt_nxt = cnt_r + bdl_pkg::CNT_W'(1);
        end
      end
      bdl_pkg::REQ_POP_BACK: begin
        if (empty) st_nxt = bdl_pkg::ST_EMPTY;
        else       cnt_nxt = cnt_r - bdl_pkg::CNT_W'(1);
      end
      bdl_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          st_nxt = bdl_pkg::ST_EMPTY;
        end else begin
          op      = bdl_pkg::OP_ERASE;
          cnt_nxt = cnt_r - bdl_pkg::CNT_W'(1);
        end
      end
      bdl_pkg::REQ_READ: begin
        if (empty)       st_nxt = bdl_pkg::ST_EMPTY;
        else if (pos_ge) st_nxt = bdl_pkg::ST_RANGE;
        else             rd_ok  = 1'b1;
      end
      bdl_pkg::REQ_WRITE: begin
        if (empty) begin
          st_nxt = bdl_pkg::ST_EMPTY;
        end else if (pos_ge) begin
          st_nxt = bdl_pkg::ST_RANGE;
        end else begin
          op     = bdl_pkg::OP_WRITE;
          op_idx = bdl_pkg::IDX_W'(pos_r);
        end
      end
      bdl_pkg::REQ_INSERT: begin
        if (full) begin
          st_nxt = bdl_pkg::ST_FULL;
        end else if (pos_gt) begin
          st_nxt = bdl_pkg::ST_RANGE;
        end else begin
          op      = bdl_pkg::OP_INSERT;
          op_idx  = bdl_pkg::IDX_W'(pos_r);
          cnt_nxt = cnt_r + bdl_pkg::CNT_W'(1);
        end
      end
      bdl_pkg::REQ_ERASE: begin
        if (empty) begin
          st_nxt = bdl_pkg::ST_EMPTY;
        end else if (pos_ge) begin
          st_nxt = bdl_pkg::ST_RANGE;
        end else begin
          op      = bdl_pkg::OP_ERASE;
          op_idx  = bdl_pkg::IDX_W'(pos_r);
          cnt_nxt = cnt_r - bdl_pkg::CNT_W'(1);
        end
      end
      bdl_pkg::REQ_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        op = bdl_pkg::OP_NONE;
      end
    endcase
  end

  // per-entry next value: hold, write, shift up or shift down
  always_comb begin
    for (int k = 0; k < bdl_pkg::DEPTH; k++) begin
      ent_nxt[k] = entries_r[k];
      case (op)
        bdl_pkg::OP_WRITE: begin
          if (bdl_pkg::IDX_W'(k) == op_idx) ent_nxt[k] = val_w;
        end
        bdl_pkg::OP_INSERT: begin
          if (bdl_pkg::IDX_W'(k) == op_idx) begin
            ent_nxt[k] = val_w;
          end else if (bdl_pkg::IDX_W'(k) > op_idx) begin
            ent_nxt[k] = entries_r[(k + bdl_pkg::DEPTH - 1) % bdl_pkg::DEPTH];
          end
        end
        bdl_pkg::OP_ERASE: begin
          if ((k < bdl_pkg::DEPTH - 1) && (bdl_pkg::IDX_W'(k) >= op_idx)) begin
            ent_nxt[k] = entries_r[(k + 1) % bdl_pkg::DEPTH];
          end
        end
        default: begin
          ent_nxt[k] = entries_r[k];
        end
      endcase
    end
  end

  // element storage, no reset: only slots below the count are read
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int k = 0; k < bdl_pkg::DEPTH; k++) begin
        entries_r[k] <= ent_nxt[k];
      end
    end
  end

  // element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  // one indexed read per cycle: position while executing, last slot after
  assign rd_addr = cmd.exec ? bdl_pkg::IDX_W'(pos_r)
                            : bdl_pkg::IDX_W'(cnt_r - bdl_pkg::CNT_W'(1));
  assign rd_word = entries_r[rd_addr];

  // read word and status of the executing request
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r     <= rd_ok ? bdl_pkg::FIELD_W'(rd_word) : '0;
      status_r <= st_nxt;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd.tail) begin
      read_out_r   <= rd_r;
      count_out_r  <= bdl_pkg::COUNT_W'(cnt_r);
      front_out_r  <= (cnt_r == '0) ? '0 : bdl_pkg::FIELD_W'(entries_r[0]);
      back_out_r   <= (cnt_r == '0) ? '0 : bdl_pkg::FIELD_W'(rd_word);
      status_out_r <= status_r;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.tail;
    end
  end

  assign out_valid       = valid_r;
  assign out_read_value  = read_out_r;
  assign out_count       = count_out_r;
  assign out_front_value = front_out_r;
  assign out_back_value  = back_out_r;
  assign out_status      = status_out_r;

endmodule

>>> src/bounded_deque_list_core.sv
// bounded deque list: top level joining sequencer and datapath
// sequence: the request is captured at the accepting edge, executed in the
//   execute state, and its result beat is registered in the tail state
// one request at a time: busy stays high through the execute then tail-read
//   sequence through the single indexed read port of the element array
// reset (rst_n low, synchronous): list empty, sequencer idle, no strobe
// the receiver cannot stall: each result beat is shown for one cycle only
module bounded_deque_list_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bdl_pkg::REQ_W-1:0]          in_req_type,
  input  logic [bdl_pkg::POS_W-1:0]          in_position,
  input  logic signed [bdl_pkg::FIELD_W-1:0] in_value,
  output logic                               out_valid,
  output logic signed [bdl_pkg::FIELD_W-1:0] out_read_value,
  output logic [bdl_pkg::COUNT_W-1:0]        out_count,
  output logic signed [bdl_pkg::FIELD_W-1:0] out_front_value,
  output logic signed [bdl_pkg::FIELD_W-1:0] out_back_value,
  output logic [bdl_pkg::ST_W-1:0]           out_status
);

  bdl_pkg::cmd_t cmd;

  // sequencer
  bdl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // storage and results
  bdl_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_status      (out_status)
  );

endmodule

>>> src/bdl_chk.sv
// port-level checker for the bounded deque list, bound to the top level
module bdl_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic [bdl_pkg::COUNT_W-1:0]        out_count,
  input logic signed [bdl_pkg::FIELD_W-1:0] out_front_value,
  input logic signed [bdl_pkg::FIELD_W-1:0] out_back_value,
  input logic [bdl_pkg::ST_W-1:0]           out_status
);

  // an accepted request beat is always followed by its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing after accepted request");

  // the block goes busy after accepting a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accepting a request");

  // count never exceeds the capacity
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_count) <= bdl_pkg::DEPTH))
    else $error("count beyond capacity");

  // an empty list reports zero front and back words
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count == '0) |-> (out_front_value == '0 && out_back_value == '0))
    else $error("nonzero front or back on an empty list");

  // a full refusal only happens at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bdl_pkg::ST_FULL)
      |-> (32'(out_count) == bdl_pkg::DEPTH))
    else $error("full refusal below capacity");

endmodule

bind bounded_deque_list_core bdl_chk u_bdl_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_count       (out_count),
  .out_front_value (out_front_value),
  .out_back_value  (out_back_value),
  .out_status      (out_status)
);

>>> tb/sv/bounded_deque_list_checker.sv
// result prediction and comparison for the bounded deque list core
module bounded_deque_list_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [bdl_pkg::REQ_W-1:0]          in_req_type,
  input  logic [bdl_pkg::POS_W-1:0]          in_position,
  input  logic signed [bdl_pkg::FIELD_W-1:0] in_value,
  input  logic                               out_valid,
  input  logic signed [bdl_pkg::FIELD_W-1:0] out_read_value,
  input  logic [bdl_pkg::COUNT_W-1:0]        out_count,
  input  logic signed [bdl_pkg::FIELD_W-1:0] out_front_value,
  input  logic signed [bdl_pkg::FIELD_W-1:0] out_back_value,
  input  logic [bdl_pkg::ST_W-1:0]           out_status,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 level
);
  import bdl_pkg::*;

  // one reply beat as the block should present it
  typedef struct packed {
    field_t             read_value;
    logic [COUNT_W-1:0] count;
    field_t             front_value;
    field_t             back_value;
    st_e                status;
  } list_reply_t;

  localparam int DUE_SLOTS = 4;

  // shadow copy of the list contents
  word_t       shadow_words [DEPTH];
  int          shadow_fill;
  list_reply_t due_replies [DUE_SLOTS];
  logic [1:0]  due_rd;
  logic [1:0]  due_wr;
  int          due_fill;
  list_reply_t oldest;
  int          fails;

  // apply one request to the shadow list and return the reply it gives
  function automatic list_reply_t apply_request(input logic [REQ_W-1:0] kind,
                                                input int slot, input field_t val);
    list_reply_t r;
    word_t       w;
    int          k;
    r = '0;
    r.status = ST_OK;
    w = val;
    case (kind)
      REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
        if (kind == REQ_PUSH_BACK) slot = shadow_fill;
        else if (kind == REQ_PUSH_FRONT) slot = 0;
        // full takes priority over a bad insert index
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else if (slot > shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (k = shadow_fill; k > slot; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[slot] = w;
          shadow_fill++;
        end
      end
      REQ_POP_BACK, REQ_POP_FRONT, REQ_ERASE: begin
        if (kind == REQ_POP_BACK) slot = shadow_fill - 1;
        else if (kind == REQ_POP_FRONT) slot = 0;
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (slot >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (k = slot; k + 1 < shadow_fill; k++) shadow_words[k] = shadow_words[k+1];
          shadow_fill--;
        end
      end
      REQ_READ, REQ_WRITE: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else if (slot >= shadow_fill) r.status = ST_RANGE;
        else if (kind == REQ_READ) r.read_value = $unsigned(shadow_words[slot]);
        else shadow_words[slot] = w;
      end
      REQ_CLEAR: begin
        shadow_fill = 0;
      end
      // spare codes leave the list alone
      default: ;
    endcase
    r.count = shadow_fill[COUNT_W-1:0];
    if (shadow_fill != 0) begin
      r.front_value = $unsigned(shadow_words[0]);
      r.back_value  = $unsigned(shadow_words[shadow_fill-1]);
    end
    return r;
  endfunction

  // compare one field of a reply beat
  task automatic check_field(input string what, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fails++;
    end
  endtask

  // compare reply beats first, then predict the request taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_fill = 0;
      due_rd      = '0;
      due_wr      = '0;
      due_fill    = 0;
    end else begin
      if (out_valid) begin
        if (due_fill == 0) begin
          $display("%0t: reply beat with none outstanding, expected none, actual status %h",
                   $time, out_status);
          fails++;
        end else begin
          oldest   = due_replies[due_rd];
          due_rd   = due_rd + 2'd1;
          due_fill = due_fill - 1;
          check_field("read_value", oldest.read_value, out_read_value);
          check_field("count", FIELD_W'(oldest.count), FIELD_W'(out_count));
          check_field("front_value", oldest.front_value, out_front_value);
          check_field("back_value", oldest.back_value, out_back_value);
          check_field("status", FIELD_W'(oldest.status), FIELD_W'(out_status));
        end
      end
      if (start && !busy) begin
        due_replies[due_wr] = apply_request(in_req_type, int'(in_position), in_value);
        due_wr   = due_wr + 2'd1;
        due_fill = due_fill + 1;
      end
    end
    fail_count <= fails;
    pending    <= due_fill;
    level      <= shadow_fill;
  end

endmodule

>>> tb/sv/bounded_deque_list_core_test.sv
// request stimulus, watchdog and verdict for the bounded deque list core
module bounded_deque_list_core_test;
  import bdl_pkg::*;

  // request codes the block treats as no-ops
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST = 4'd15;
  localparam int RANDOM_ITEMS = 1900;
  localparam int STALL_LIMIT  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int POS_TOP      = (1 << POS_W) - 1;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY,
    MIX_NOISE
  } mix_e;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [REQ_W-1:0]   in_req_type;
  logic [POS_W-1:0]   in_position;
  field_t             in_value;
  logic               out_valid;
  field_t             out_read_value;
  logic [COUNT_W-1:0] out_count;
  field_t             out_front_value;
  field_t             out_back_value;
  logic [ST_W-1:0]    out_status;

  int     fail_count;
  int     pending;
  int     level;
  int     quiet_cycles;
  logic   idle_on;
  int     sent;
  int     span;
  int     roll;
  mix_e   mix;
  logic [REQ_W-1:0] kind;
  logic [POS_W-1:0] pos;
  field_t val;
  field_t extreme_words [4] = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1};

  bounded_deque_list_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_status      (out_status)
  );

  bounded_deque_list_checker list_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending         (pending),
    .level           (level)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: ends the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bounded_deque_list_core_test NOT OK");
      $finish;
    end
  end

  // hold a request on the bus until the block takes it
  task automatic issue_request(input logic [REQ_W-1:0] k, input logic [POS_W-1:0] p,
                               input field_t v);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= k;
    in_position <= p;
    in_value    <= v;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    idle_on      = 1'b0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_req_type <= REQ_CLEAR;
    in_position <= '0;
    in_value    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty refusals, extremes, bad indices, spare codes
    issue_request(REQ_POP_BACK, 5'd0, 32'sd0);
    issue_request(REQ_POP_FRONT, 5'd0, 32'sd0);
    issue_request(REQ_READ, 5'd0, 32'sd0);
    issue_request(REQ_WRITE, 5'd0, 32'sd7);
    issue_request(REQ_ERASE, 5'd0, 32'sd0);
    issue_request(REQ_INSERT, 5'd1, 32'sd3);
    issue_request(REQ_INSERT, 5'd0, 32'sh7fffffff);
    issue_request(REQ_PUSH_BACK, 5'd0, 32'sh80000000);
    issue_request(REQ_PUSH_FRONT, 5'd31, -32'sd1);
    issue_request(REQ_READ, 5'd2, 32'sd0);
    issue_request(REQ_READ, 5'd3, 32'sd0);
    issue_request(REQ_WRITE, 5'd31, 32'sd9);
    issue_request(REQ_WRITE, 5'd1, 32'sd0);
    issue_request(REQ_INSERT, 5'd3, 32'sh5a5a5a5a);
    issue_request(REQ_INSERT, 5'd5, 32'sd1);
    issue_request(REQ_ERASE, 5'd4, 32'sd0);
    issue_request(REQ_ERASE, 5'd1, 32'sd0);
    issue_request(REQ_POP_FRONT, 5'd0, 32'sd0);
    issue_request(REQ_POP_BACK, 5'd0, 32'sd0);
    issue_request(REQ_SPARE_LAST, 5'd16, -32'sd1);
    issue_request(REQ_CLEAR + 4'd1, 5'd0, 32'sd0);
    issue_request(REQ_PUSH_BACK, 5'd0, 32'sh12345678);
    issue_request(REQ_CLEAR, 5'd0, 32'sd0);

    // random: phases that fill, drain, mix or throw noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      mix = (roll < 3) ? MIX_FILL : (roll < 6) ? MIX_DRAIN : (roll < 9) ? MIX_ANY : MIX_NOISE;
      idle_on = ($urandom_range(0, 3) != 0);
      span = $urandom_range(20, 60);
      repeat (span) begin
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_FILL: begin
            if (roll < 30) kind = REQ_PUSH_BACK;
            else if (roll < 55) kind = REQ_PUSH_FRONT;
            else if (roll < 75) kind = REQ_INSERT;
            else kind = REQ_W'($urandom_range(REQ_POP_BACK, REQ_ERASE));
          end
          MIX_DRAIN: begin
            if (roll < 25) kind = REQ_POP_BACK;
            else if (roll < 50) kind = REQ_POP_FRONT;
            else if (roll < 70) kind = REQ_ERASE;
            else kind = REQ_W'($urandom_range(REQ_PUSH_BACK, REQ_ERASE));
          end
          MIX_ANY: begin
            if (roll < 3) kind = REQ_CLEAR;
            else kind = REQ_W'($urandom_range(REQ_PUSH_BACK, REQ_ERASE));
          end
          default: begin
            kind = REQ_W'($urandom_range(REQ_PUSH_BACK, REQ_SPARE_LAST));
          end
        endcase
        // mostly valid indices, sometimes anything the port can carry
        if ($urandom_range(0, 7) == 0) pos = POS_W'($urandom_range(0, POS_TOP));
        else pos = POS_W'($urandom_range(0, level));
        if ($urandom_range(0, 7) == 0) val = extreme_words[2'($urandom_range(0, 3))];
        else val = $urandom;
        issue_request(kind, pos, val);
        if (kind <= REQ_CLEAR) sent++;
      end
    end

    // let the last replies come back
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bounded_deque_list_core_test OK");
    end else begin
      $display("bounded_deque_list_core_test NOT OK");
    end
    $finish;
  end

endmodule
